@@ sv/modexp_pkg.sv @@
package modexp_pkg;

    // Default operand width and the reset values of the two registers.
    localparam int          OPERAND_WIDTH_DEFAULT = 64;
    localparam logic [63:0] PRIME_A               = 64'd4294967291;
    localparam logic [63:0] PRIME_B               = 64'd4294967279;
    localparam logic [63:0] RESET_EXPONENT        = 64'd65537;
    localparam logic [63:0] RESET_MODULUS         = PRIME_A * PRIME_B;

    // Configuration register indexes.
    localparam int         CFG_INDEX_WIDTH = 1;
    localparam logic [0:0] REG_EXPONENT    = 1'b0;
    localparam logic [0:0] REG_MODULUS     = 1'b1;

    // Sequencer states of the exponentiation core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL_RES,
        ST_SQUARE,
        ST_DONE
    } core_state_t;

endpackage

@@ sv/modexp_mulmod.sv @@
module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] op_a,
    input  logic [OPERAND_WIDTH-1:0] op_b,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] product
);

    localparam int XW    = OPERAND_WIDTH + 2;
    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

    logic [OPERAND_WIDTH-1:0] acc_reg, acc_next;
    logic [OPERAND_WIDTH-1:0] a_reg, a_next;
    logic [OPERAND_WIDTH-1:0] b_reg, b_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [XW-1:0] sum;
    logic [XW-1:0] mod_1x;
    logic [XW-1:0] mod_2x;
    logic [XW-1:0] diff_1x;
    logic [XW-1:0] diff_2x;
    logic [OPERAND_WIDTH-1:0] step;

    // One multiplier bit per cycle, MSB first: acc = (2*acc + bit*a) mod m.
    // The sum stays below three times the modulus, so at most two
    // subtractions are needed and both are formed side by side.
    always_comb begin
        sum     = {1'b0, acc_reg, 1'b0} + (b_reg[OPERAND_WIDTH-1] ? XW'(a_reg) : '0);
        mod_1x  = XW'(modulus);
        mod_2x  = {1'b0, modulus, 1'b0};
        diff_1x = sum - mod_1x;
        diff_2x = sum - mod_2x;
        if (sum >= mod_2x) begin
            step = diff_2x[OPERAND_WIDTH-1:0];
        end else if (sum >= mod_1x) begin
            step = diff_1x[OPERAND_WIDTH-1:0];
        end else begin
            step = sum[OPERAND_WIDTH-1:0];
        end
    end

    // Operand latch, shift and step counting.
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            cnt_next  = CNT_W'(OPERAND_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = step;
            b_next   = {b_reg[OPERAND_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ sv/modexp_core.sv @@
module modexp_core
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OPERAND_WIDTH-1:0] in_base,
    input  logic [OPERAND_WIDTH-1:0] exponent,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output logic                     res_valid,
    input  logic                     res_take,
    output logic [OPERAND_WIDTH-1:0] res_data
);

    core_state_t state_reg, state_next;

    logic [OPERAND_WIDTH-1:0] exp_reg, exp_next;
    logic [OPERAND_WIDTH-1:0] result_reg, result_next;
    logic [OPERAND_WIDTH-1:0] power_reg, power_next;

    logic                     mm_start;
    logic [OPERAND_WIDTH-1:0] mm_a;
    logic [OPERAND_WIDTH-1:0] mm_b;
    logic                     mm_done;
    logic [OPERAND_WIDTH-1:0] mm_product;
    logic                     exp_last;

    // Shared modular multiplier; the base reduction runs on it as base * 1.
    modexp_mulmod #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus),
        .done    (mm_done),
        .product (mm_product)
    );

    // True when the current exponent bit is the last one set.
    assign exp_last = (exp_reg[OPERAND_WIDTH-1:1] == '0);

    // Sequencer: scan the exponent LSB first, multiply then square.
    always_comb begin
        state_next  = state_reg;
        exp_next    = exp_reg;
        result_next = result_reg;
        power_next  = power_reg;
        mm_start    = 1'b0;
        mm_a        = power_reg;
        mm_b        = power_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    exp_next = exponent;
                    if (exponent == '0) begin
                        result_next = OPERAND_WIDTH'(1);
                        state_next  = ST_DONE;
                    end else if (modulus == '0) begin
                        result_next = '0;
                        state_next  = ST_DONE;
                    end else begin
                        // A modulus of one reduces the initial one to zero.
                        result_next = (modulus == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
                        mm_start    = 1'b1;
                        mm_a        = OPERAND_WIDTH'(1);
                        mm_b        = in_base;
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_done) begin
                    power_next = mm_product;
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                if (exp_reg[0]) begin
                    mm_start   = 1'b1;
                    mm_a       = result_reg;
                    mm_b       = power_reg;
                    state_next = ST_MUL_RES;
                end else begin
                    exp_next = exp_reg >> 1;
                    if (exp_last) begin
                        state_next = ST_DONE;
                    end else begin
                        mm_start   = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_MUL_RES: begin
                if (mm_done) begin
                    result_next = mm_product;
                    exp_next    = exp_reg >> 1;
                    if (exp_last) begin
                        state_next = ST_DONE;
                    end else begin
                        mm_start   = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                if (mm_done) begin
                    power_next = mm_product;
                    state_next = ST_BIT;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg    <= exp_next;
        result_reg <= result_next;
        power_reg  <= power_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = result_reg;

endmodule

@@ sv/modular_exponentiation_64_top.sv @@
// Modular exponentiation, right-to-left square and multiply.
// Input channel s_*: one base per transfer. Result channel m_*: one result
// per base, base ** exponent mod modulus, in the order the bases arrived.
// Configuration channel cfg_*: index 0 writes the exponent, index 1 the
// modulus; cfg_ready is always high and writes belong in idle periods.
// Order of work: the base is reduced first, then each set exponent bit
// costs one modular multiply and each exponent bit below the top set bit
// one squaring. An exponent of zero or a modulus of zero finishes without
// using the multiplier. The shared bit-serial modular multiplier handles
// one multiplier bit per cycle.
// One base is in work at a time; s_tready is high while the core is idle.
// A finished result moves into the output register, so the next base can
// be taken while m_tvalid waits on a stalled receiver; the core then holds
// its next result until the output register is free.
// Reset (aresetn low, synchronous) drops any item in work and any waiting
// result, and restores exponent 65537 and the default modulus.
module modular_exponentiation_64_top
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: base_value, then zero fill to whole bytes.
    input  logic [((OPERAND_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: power_result, then zero fill to whole bytes.
    output logic [((OPERAND_WIDTH+7)/8)*8-1:0]     m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]             cfg_index,
    input  logic [OPERAND_WIDTH-1:0]               cfg_data
);

    localparam int TDATA_W = ((OPERAND_WIDTH + 7) / 8) * 8;

    logic [OPERAND_WIDTH-1:0] exponent_reg, exponent_next;
    logic [OPERAND_WIDTH-1:0] modulus_reg, modulus_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OPERAND_WIDTH-1:0] out_data_reg, out_data_next;

    logic                     res_valid;
    logic                     res_take;
    logic [OPERAND_WIDTH-1:0] res_data;

    modexp_core #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_base   (s_tdata[OPERAND_WIDTH-1:0]),
        .exponent  (exponent_reg),
        .modulus   (modulus_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data)
    );

    // Configuration register writes.
    assign cfg_ready = 1'b1;

    always_comb begin
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_EXPONENT: exponent_next = cfg_data;
                REG_MODULUS:  modulus_next  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Output register: loads when empty or when its result is transferred.
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take) begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg  <= RESET_EXPONENT[OPERAND_WIDTH-1:0];
            modulus_reg   <= RESET_MODULUS[OPERAND_WIDTH-1:0];
            out_valid_reg <= 1'b0;
        end else begin
            exponent_reg  <= exponent_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);

endmodule

@@ sv/modexp_checker.sv @@
module modexp_protocol_checker
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((OPERAND_WIDTH+7)/8)*8-1:0] m_tdata
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // An accepted base takes the core out of idle in the cycle after the transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a transfer");

    // A new result only appears after the core has been busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared from an idle core");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind modular_exponentiation_64_top modexp_protocol_checker #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
) u_modexp_checker (.*);
